FILE: rtl/omeb_pkg.sv
// Shared types and constants for the ordered merge with end-of-stream barrier.
package omeb_pkg;

    // Fixed field widths
    localparam int PORT_W   = 2;
    localparam int IDENT_W  = 32;
    localparam int HANDLE_W = 32;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 3;

    // Queue entry: {eos, ident, handle}
    localparam int ENTRY_W = 1 + IDENT_W + HANDLE_W;

    // Parameter defaults
    localparam int PORTS_DEF       = 4;
    localparam int QUEUE_DEPTH_DEF = 8;

    // Results per drain before the drain yields
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Reset value of active_ports
    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(4);

    typedef enum logic [STATUS_W-1:0] {
        ST_DATA     = 2'd0,
        ST_EOS      = 2'd1,
        ST_FULL     = 2'd2,
        ST_BAD_PORT = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_FLUSH
    } state_t;

endpackage

FILE: rtl/omeb_push_if.sv
// Push channel: one frame record per beat.
interface omeb_push_if
    import omeb_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [PORT_W-1:0]          port;
    logic                       is_eos;
    logic signed [IDENT_W-1:0]  frame_ident;
    logic [HANDLE_W-1:0]        frame_handle;

    modport source (output valid, port, is_eos, frame_ident, frame_handle, input ready);
    modport sink   (input valid, port, is_eos, frame_ident, frame_handle, output ready);
endinterface

FILE: rtl/omeb_result_if.sv
// Result channel: one merged, end-of-stream or error result per beat.
interface omeb_result_if
    import omeb_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic [PORT_W-1:0]          out_port;
    logic signed [IDENT_W-1:0]  out_ident;
    logic [HANDLE_W-1:0]        out_handle;
    logic                       last;

    modport source (output valid, status, out_port, out_ident, out_handle, last, input ready);
    modport sink   (input valid, status, out_port, out_ident, out_handle, last, output ready);
endinterface

FILE: rtl/omeb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module omeb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/ordered_merge_with_eos_barrier_unit.sv
// Top level of the ordered merge with end-of-stream barrier.
//
// Usage: each push beat carries one record (data frame or end-of-stream)
// for one input port; the record goes into that port's FIFO in a shared
// queue RAM. After a push the block drains: while an active port holds a
// data frame at its head, the smallest signed identifier is emitted
// (ties to the lowest port); when all active ports show end-of-stream,
// they are all popped and one end-of-stream result is emitted.
// A push to an inactive port or a full FIFO gives one error result and
// is dropped. cfg_wr_en/cfg_wr_data set active_ports (0 acts as 1,
// values above PORTS act as PORTS); write it only while idle.
// Timing: an error result is in the output register the cycle after its
// beat. A drain step reads each active head from the RAM, one port per
// cycle, then decides; a result leaves once the next step is decided,
// the final one through the flush state.
// A drain stops after MAX_RESULTS results. push.ready is low while a
// drain runs, and while the output register holds a beat not taken.
// Reset clears pointers, fill counts and the FSM; queue RAM is not
// cleared. A stalled receiver holds the drain at its next decision.
module ordered_merge_with_eos_barrier_unit
    import omeb_pkg::*;
#(
    parameter int PORTS       = PORTS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    omeb_push_if.sink          push,
    omeb_result_if.source      result,
    input  logic               cfg_wr_en,
    input  logic [CFG_W-1:0]   cfg_wr_data
);

    localparam int PW  = $clog2(PORTS);
    localparam int AW  = $clog2(PORTS + 1);
    localparam int XW  = (AW > CFG_W) ? AW : CFG_W;
    localparam int QW  = $clog2(QUEUE_DEPTH);
    localparam int FW  = $clog2(QUEUE_DEPTH + 1);
    localparam int SW  = FW + 1;
    localparam int MD  = PORTS * QUEUE_DEPTH;
    localparam int MAW = $clog2(MD);

    state_t state_reg, state_next;

    logic [CFG_W-1:0] cfg_reg;
    logic [QW-1:0]    rp_reg   [PORTS];
    logic [FW-1:0]    fill_reg [PORTS];

    // Scan state
    logic [XW-1:0]    scan_reg;
    logic             rd_pend_reg, rd_last_reg, rd_ne_reg;
    logic [PW-1:0]    rd_port_reg;
    logic             found_reg;
    logic [XW-1:0]    neos_reg;
    logic [PW-1:0]    best_reg;
    logic signed [IDENT_W-1:0] best_id_reg;
    logic [HANDLE_W-1:0]       best_handle_reg;
    logic [CNT_W-1:0] cnt_reg;

    // Result held until the next step tells whether it is the last one
    logic                      pend_valid_reg;
    status_t                   pend_status_reg;
    logic [PORT_W-1:0]         pend_port_reg;
    logic signed [IDENT_W-1:0] pend_ident_reg;
    logic [HANDLE_W-1:0]       pend_handle_reg;

    // Output register
    logic                      ovalid_reg;
    status_t                   ostatus_reg;
    logic [PORT_W-1:0]         oport_reg;
    logic signed [IDENT_W-1:0] oident_reg;
    logic [HANDLE_W-1:0]       ohandle_reg;
    logic                      olast_reg;

    // Effective active port count
    logic [XW-1:0] cfg_x, act_x, port_x;
    always_comb
    begin
        cfg_x  = XW'(cfg_reg);
        port_x = XW'(push.port);
        if (cfg_x == '0)
        begin
            act_x = XW'(1);
        end
        else if (cfg_x > XW'(PORTS))
        begin
            act_x = XW'(PORTS);
        end
        else
        begin
            act_x = cfg_x;
        end
    end

    // Pointer table index and RAM addressing
    logic [PW-1:0]  ptr_idx;
    logic [QW-1:0]  idx_rp;
    logic [FW-1:0]  idx_fill;
    logic [SW-1:0]  wsum;
    logic [QW-1:0]  woff;
    logic [MAW-1:0] base_addr, ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
    logic           ram_we;

    always_comb
    begin
        case (state_reg)
            S_IDLE:   ptr_idx = port_x[PW-1:0];
            S_SCAN:   ptr_idx = scan_reg[PW-1:0];
            S_DECIDE: ptr_idx = best_reg;
            default:  ptr_idx = best_reg;
        endcase
        idx_rp    = rp_reg[ptr_idx];
        idx_fill  = fill_reg[ptr_idx];
        wsum      = SW'(idx_rp) + SW'(idx_fill);
        woff      = (wsum >= SW'(QUEUE_DEPTH)) ? QW'(wsum - SW'(QUEUE_DEPTH)) : QW'(wsum);
        base_addr = MAW'(ptr_idx) * MAW'(QUEUE_DEPTH);
        ram_waddr = base_addr + MAW'(woff);
        ram_raddr = base_addr + MAW'(idx_rp);
        ram_wdata = {push.is_eos, push.frame_ident, push.frame_handle};
    end

    omeb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MD)
    ) u_queue_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic                      rd_eos;
    logic signed [IDENT_W-1:0] rd_ident;
    logic [HANDLE_W-1:0]       rd_handle;
    assign {rd_eos, rd_ident, rd_handle} = ram_rdata;

    // FSM outputs
    logic out_free, accept, bad_port, full_q, emit_drop;
    logic issue, act_hit, step, emit_pend, emit_flush, cap_hit;

    assign out_free = !ovalid_reg || result.ready;
    assign act_hit  = found_reg || (neos_reg == act_x);
    assign cap_hit  = (cnt_reg + CNT_W'(1)) == CNT_W'(MAX_RESULTS);
    assign bad_port = port_x >= act_x;
    assign full_q   = idx_fill == FW'(QUEUE_DEPTH);

    always_comb
    begin
        push.ready = 1'b0;
        accept     = 1'b0;
        ram_we     = 1'b0;
        emit_drop  = 1'b0;
        issue      = 1'b0;
        step       = 1'b0;
        emit_pend  = 1'b0;
        emit_flush = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                push.ready = out_free;
                accept     = push.valid && out_free;
                ram_we     = accept && !bad_port && !full_q;
                emit_drop  = accept && (bad_port || full_q);
            end
            S_SCAN:
            begin
                issue = scan_reg < act_x;
            end
            S_DECIDE:
            begin
                step      = act_hit && (!pend_valid_reg || out_free);
                emit_pend = step && pend_valid_reg;
            end
            S_FLUSH:
            begin
                emit_flush = out_free;
            end
            default:
            begin
                push.ready = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (ram_we)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (rd_pend_reg && rd_last_reg)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (act_hit)
                begin
                    if (step)
                    begin
                        state_next = cap_hit ? S_FLUSH : S_SCAN;
                    end
                end
                else
                begin
                    state_next = pend_valid_reg ? S_FLUSH : S_IDLE;
                end
            end
            S_FLUSH:
            begin
                if (emit_flush)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    logic scan_start;
    assign scan_start = ram_we || (step && !cap_hit);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cfg_reg        <= ACTIVE_RESET;
            ovalid_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            scan_reg       <= '0;
            rd_pend_reg    <= 1'b0;
            found_reg      <= 1'b0;
            neos_reg       <= '0;
            for (int i = 0; i < PORTS; i++)
            begin
                rp_reg[i]   <= '0;
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                cfg_reg <= cfg_wr_data;
            end

            // Output register valid
            if (emit_drop || emit_pend || emit_flush)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                ovalid_reg <= 1'b0;
            end

            // Pending result
            if (step)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (emit_flush)
            begin
                pend_valid_reg <= 1'b0;
            end

            // Result count of this drain
            if (ram_we)
            begin
                cnt_reg <= '0;
            end
            else if (step)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end

            // Head scan: issue one read a cycle, compare the cycle after
            rd_pend_reg <= issue;
            if (scan_start)
            begin
                scan_reg  <= '0;
                found_reg <= 1'b0;
                neos_reg  <= '0;
            end
            else
            begin
                if (issue)
                begin
                    scan_reg <= scan_reg + XW'(1);
                end
                if (rd_pend_reg && rd_ne_reg)
                begin
                    if (rd_eos)
                    begin
                        neos_reg <= neos_reg + XW'(1);
                    end
                    else if (!found_reg || (rd_ident < best_id_reg))
                    begin
                        found_reg <= 1'b1;
                    end
                end
            end

            // Push into the port FIFO
            if (ram_we)
            begin
                fill_reg[ptr_idx] <= idx_fill + FW'(1);
            end

            // Pop the winner, or every active port on end-of-stream
            if (step)
            begin
                if (found_reg)
                begin
                    rp_reg[best_reg]   <= (idx_rp == QW'(QUEUE_DEPTH - 1)) ? '0
                                                                           : idx_rp + QW'(1);
                    fill_reg[best_reg] <= idx_fill - FW'(1);
                end
                else
                begin
                    for (int i = 0; i < PORTS; i++)
                    begin
                        if (XW'(i) < act_x)
                        begin
                            rp_reg[i]   <= (rp_reg[i] == QW'(QUEUE_DEPTH - 1)) ? '0
                                                                               : rp_reg[i] + QW'(1);
                            fill_reg[i] <= fill_reg[i] - FW'(1);
                        end
                    end
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_port_reg <= scan_reg[PW-1:0];
            rd_last_reg <= scan_reg == (act_x - XW'(1));
            rd_ne_reg   <= idx_fill != '0;
        end

        if (rd_pend_reg && rd_ne_reg && !rd_eos && (!found_reg || (rd_ident < best_id_reg)))
        begin
            best_reg        <= rd_port_reg;
            best_id_reg     <= rd_ident;
            best_handle_reg <= rd_handle;
        end

        if (step)
        begin
            if (found_reg)
            begin
                pend_status_reg <= ST_DATA;
                pend_port_reg   <= PORT_W'(best_reg);
                pend_ident_reg  <= best_id_reg;
                pend_handle_reg <= best_handle_reg;
            end
            else
            begin
                pend_status_reg <= ST_EOS;
                pend_port_reg   <= '0;
                pend_ident_reg  <= '0;
                pend_handle_reg <= '0;
            end
        end

        if (emit_drop)
        begin
            ostatus_reg <= bad_port ? ST_BAD_PORT : ST_FULL;
            oport_reg   <= push.port;
            oident_reg  <= '0;
            ohandle_reg <= '0;
            olast_reg   <= 1'b1;
        end
        else if (emit_pend || emit_flush)
        begin
            ostatus_reg <= pend_status_reg;
            oport_reg   <= pend_port_reg;
            oident_reg  <= pend_ident_reg;
            ohandle_reg <= pend_handle_reg;
            olast_reg   <= emit_flush;
        end
    end

    assign result.valid      = ovalid_reg;
    assign result.status     = ostatus_reg;
    assign result.out_port   = oport_reg;
    assign result.out_ident  = oident_reg;
    assign result.out_handle = ohandle_reg;
    assign result.last       = olast_reg;

    // No held result once the drain is over
    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !pend_valid_reg)
        else $error("pending result left behind in idle");

    // A non-final beat means the drain is still running
    a_not_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !olast_reg) |-> state_reg != S_IDLE)
        else $error("non-final result with drain finished");

    // Drain never exceeds the result cap
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_RESULTS))
        else $error("drain exceeded result cap");

    // RAM read data is only consumed during the head scan
    a_scan_read: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> state_reg == S_SCAN)
        else $error("head read outside scan");

    // A drain step that pops a data frame takes it from a non-empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (step && found_reg) |-> idx_fill != '0)
        else $error("pop from empty queue");

endmodule
